>>> rtl/scl_pkg.sv
// scl_pkg: shared types, token codes and character classes for the small C lexer.
// No dependencies; every module in rtl/ imports it.
package scl_pkg;

  localparam int DEF_KEYWORD_CHARS = 6;
  localparam int DEF_POSITION_BITS = 32;

  // Result queue between front and back; a power of two so pointers wrap freely.
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  localparam logic [4:0] KIND_AUTO    = 5'd0;
  localparam logic [4:0] KIND_EXTERN  = 5'd1;
  localparam logic [4:0] KIND_RETURN  = 5'd2;
  localparam logic [4:0] KIND_IDENT   = 5'd3;
  localparam logic [4:0] KIND_INT     = 5'd4;
  localparam logic [4:0] KIND_LPAREN  = 5'd5;
  localparam logic [4:0] KIND_RPAREN  = 5'd6;
  localparam logic [4:0] KIND_LBRACE  = 5'd7;
  localparam logic [4:0] KIND_RBRACE  = 5'd8;
  localparam logic [4:0] KIND_SEMI    = 5'd9;
  localparam logic [4:0] KIND_ASSIGN  = 5'd10;
  localparam logic [4:0] KIND_PLUS    = 5'd11;
  localparam logic [4:0] KIND_MINUS   = 5'd12;
  localparam logic [4:0] KIND_STAR    = 5'd13;
  localparam logic [4:0] KIND_DIV     = 5'd14;
  localparam logic [4:0] KIND_COMMA   = 5'd15;
  localparam logic [4:0] KIND_INVALID = 5'd16;
  localparam logic [4:0] KIND_END     = 5'd17;

  localparam logic [31:0] KW_AUTO   = "auto";
  localparam logic [47:0] KW_EXTERN = "extern";
  localparam logic [47:0] KW_RETURN = "return";

  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_SLASH = "/";

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_STAR    = 3'd5,
    MODE_HALTED  = 3'd6
  } mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
    logic [7:0]  bad;
    logic        last;
  } tok_t;

  // Up to two results per request; v1 only together with v0.
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } push_t;

  typedef struct packed {
    logic valid;
    tok_t tok;
  } q_head_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } punct_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic punct_t punct_kind(input logic [7:0] c);
    punct_t p;
    p.hit = 1'b1;
    unique case (c)
      "(":     p.kind = KIND_LPAREN;
      ")":     p.kind = KIND_RPAREN;
      "{":     p.kind = KIND_LBRACE;
      "}":     p.kind = KIND_RBRACE;
      ";":     p.kind = KIND_SEMI;
      "=":     p.kind = KIND_ASSIGN;
      "+":     p.kind = KIND_PLUS;
      "-":     p.kind = KIND_MINUS;
      "*":     p.kind = KIND_STAR;
      ",":     p.kind = KIND_COMMA;
      default: begin
        p.hit  = 1'b0;
        p.kind = KIND_INVALID;
      end
    endcase
    return p;
  endfunction

endpackage

>>> rtl/scl_in_if.sv
// scl_in_if: character request channel (valid/ready plus action and byte).
// No dependencies.
interface scl_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;

  modport source (output valid, action, char_code, input ready);
  modport sink   (input valid, action, char_code, output ready);
endinterface

>>> rtl/scl_out_if.sv
// scl_out_if: token request channel (valid/ready plus token fields).
// No dependencies.
interface scl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] start_position;
  logic [15:0] token_length;
  logic [7:0]  bad_char;
  logic        last_of_run;

  modport source (output valid, token_kind, start_position, token_length, bad_char,
                  last_of_run, input ready);
  modport sink   (input valid, token_kind, start_position, token_length, bad_char,
                  last_of_run, output ready);
endinterface

>>> rtl/scl_front.sv
// scl_front: lexer mode machine; classifies each character request and pushes
// zero, one or two tokens into the result queue. Uses scl_pkg and scl_in_if.
module scl_front #(
  parameter int KEYWORD_CHARS = scl_pkg::DEF_KEYWORD_CHARS,
  parameter int POSITION_BITS = scl_pkg::DEF_POSITION_BITS
) (
  input  logic            clk,
  input  logic            rst,
  scl_in_if.sink          chars,
  output scl_pkg::push_t  push,
  input  logic            room
);
  import scl_pkg::*;

  localparam int KW_IW = $clog2(KEYWORD_CHARS);

  mode_t                    mode, mode_next;
  logic [7:0]               prefix [KEYWORD_CHARS];
  logic [POSITION_BITS-1:0] tbegin, tbegin_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [15:0]              count, count_next, count_inc;
  logic                     pfx_we;
  logic [KW_IW-1:0]         pfx_idx;

  logic       acc;
  logic [7:0] c;
  logic       c_letter, c_digit, c_space, c_slash, c_star, c_under;
  punct_t     pk;
  logic       cont, ends_word, idle_like, relex, has_pend, fi_emit;
  logic [4:0] wkind;
  tok_t       pend_tok, fi_tok, end_tok;

  assign chars.ready = room;
  assign acc         = chars.valid && room;
  assign c           = chars.char_code;

  assign c_letter = is_letter(c);
  assign c_digit  = is_digit(c);
  assign c_space  = is_space(c);
  assign c_slash  = (c == CH_SLASH);
  assign c_star   = (c == CH_STAR);
  assign c_under  = (c == CH_UNDER);
  assign pk       = punct_kind(c);

  assign count_inc = (count == 16'hFFFF) ? count : count + 16'd1;

  always_comb begin
    if (count == 16'd4 && {prefix[0], prefix[1], prefix[2], prefix[3]} == KW_AUTO) begin
      wkind = KIND_AUTO;
    end else if (count == 16'd6 && {prefix[0], prefix[1], prefix[2], prefix[3],
                                   prefix[4], prefix[5]} == KW_EXTERN) begin
      wkind = KIND_EXTERN;
    end else if (count == 16'd6 && {prefix[0], prefix[1], prefix[2], prefix[3],
                                   prefix[4], prefix[5]} == KW_RETURN) begin
      wkind = KIND_RETURN;
    end else begin
      wkind = KIND_IDENT;
    end
  end

  always_comb begin
    cont      = 1'b0;
    ends_word = 1'b0;
    idle_like = 1'b0;
    has_pend  = 1'b0;
    unique case (mode)
      MODE_IDENT: begin
        has_pend  = 1'b1;
        cont      = c_letter || c_digit || c_under;
        ends_word = !cont;
      end
      MODE_NUMBER: begin
        has_pend  = 1'b1;
        cont      = c_digit;
        ends_word = !cont;
      end
      MODE_SLASH: begin
        has_pend  = 1'b1;
        ends_word = !c_star;
      end
      MODE_COMMENT, MODE_STAR, MODE_HALTED: begin
      end
      default: idle_like = 1'b1;
    endcase
  end

  assign relex   = idle_like || ends_word;
  assign fi_emit = relex && !c_space && !c_letter && !c_digit && !c_slash;

  always_comb begin
    pend_tok.kind  = (mode == MODE_NUMBER) ? KIND_INT :
                     (mode == MODE_SLASH)  ? KIND_DIV : wkind;
    pend_tok.start = 32'(tbegin);
    pend_tok.len   = (mode == MODE_SLASH) ? 16'd1 : count;
    pend_tok.bad   = 8'd0;
    pend_tok.last  = 1'b0;

    fi_tok.kind    = pk.hit ? pk.kind : KIND_INVALID;
    fi_tok.start   = 32'(pos);
    fi_tok.len     = 16'd1;
    fi_tok.bad     = pk.hit ? 8'd0 : c;
    fi_tok.last    = 1'b0;

    end_tok.kind   = KIND_END;
    end_tok.start  = 32'(pos);
    end_tok.len    = 16'd0;
    end_tok.bad    = 8'd0;
    end_tok.last   = 1'b1;
  end

  // Token output
  always_comb begin
    push = '0;
    if (acc) begin
      if (chars.action) begin
        if (has_pend) begin
          push.v0 = 1'b1;
          push.t0 = pend_tok;
          push.v1 = 1'b1;
          push.t1 = end_tok;
        end else begin
          push.v0 = 1'b1;
          push.t0 = end_tok;
        end
      end else if (ends_word) begin
        push.v0      = 1'b1;
        push.t0      = pend_tok;
        push.t0.last = !fi_emit;
        push.v1      = fi_emit;
        push.t1      = fi_tok;
        push.t1.last = 1'b1;
      end else if (fi_emit) begin
        push.v0      = 1'b1;
        push.t0      = fi_tok;
        push.t0.last = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    mode_next   = mode;
    tbegin_next = tbegin;
    count_next  = count;
    pos_next    = pos;
    pfx_we      = 1'b0;
    pfx_idx     = count[KW_IW-1:0];
    if (acc) begin
      if (chars.action) begin
        mode_next   = MODE_IDLE;
        tbegin_next = '0;
        count_next  = 16'd0;
        pos_next    = '0;
      end else begin
        pos_next = pos + POSITION_BITS'(1);
        if (relex) begin
          priority if (c_space) begin
            mode_next = MODE_IDLE;
          end else if (c_letter || c_digit) begin
            mode_next   = c_letter ? MODE_IDENT : MODE_NUMBER;
            tbegin_next = pos;
            count_next  = 16'd1;
            pfx_we      = 1'b1;
            pfx_idx     = '0;
          end else if (c_slash) begin
            mode_next   = MODE_SLASH;
            tbegin_next = pos;
            count_next  = 16'd0;
          end else if (pk.hit) begin
            mode_next = MODE_IDLE;
          end else begin
            mode_next = MODE_HALTED;
          end
        end else if (cont) begin
          pfx_we     = (count < 16'(KEYWORD_CHARS));
          count_next = count_inc;
        end else begin
          unique case (mode)
            MODE_SLASH:   mode_next = MODE_COMMENT;
            MODE_COMMENT: if (c_star) mode_next = MODE_STAR;
            MODE_STAR: begin
              if (c_slash) begin
                mode_next = MODE_IDLE;
              end else if (!c_star) begin
                mode_next = MODE_COMMENT;
              end
            end
            default: mode_next = mode;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      tbegin <= '0;
      count  <= 16'd0;
      pos    <= '0;
    end else begin
      mode   <= mode_next;
      tbegin <= tbegin_next;
      count  <= count_next;
      pos    <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pfx_we) prefix[pfx_idx] <= c;
  end

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (acc && chars.action) |-> push.v0 &&
      (push.v1 ? push.t1.kind == KIND_END : push.t0.kind == KIND_END))
    else $error("end request did not close with an end token");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (acc && !chars.action && mode == MODE_HALTED) |-> !push.v0)
    else $error("token emitted while halted");

endmodule

>>> rtl/scl_queue.sv
// scl_queue: short result queue, two writes and one read per cycle.
// Uses scl_pkg.
module scl_queue (
  input  logic             clk,
  input  logic             rst,
  input  scl_pkg::push_t   push,
  output logic             room,
  output scl_pkg::q_head_t head,
  input  logic             pop
);
  import scl_pkg::*;

  tok_t            ent [QUEUE_DEPTH];
  logic [QP_W-1:0] wp, rp;
  logic [QP_W:0]   cnt;
  logic [1:0]      n_push;

  assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
  assign room       = (cnt <= (QP_W+1)'(QUEUE_DEPTH - 2));
  assign head.valid = (cnt != '0);
  assign head.tok   = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + QP_W'(n_push);
      rp  <= rp + QP_W'(pop);
      cnt <= cnt + (QP_W+1)'(n_push) - (QP_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) ent[wp] <= push.t0;
    if (push.v1) ent[wp + QP_W'(1)] <= push.t1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QP_W+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0)
    else $error("second push without first");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

>>> rtl/scl_back.sv
// scl_back: output register; drains the result queue onto the token channel.
// Uses scl_pkg and scl_out_if.
module scl_back (
  input  logic             clk,
  input  logic             rst,
  input  scl_pkg::q_head_t head,
  output logic             pop,
  scl_out_if.source        tokens
);
  import scl_pkg::*;

  logic ov;
  tok_t tok;
  logic load;

  assign load = head.valid && (!ov || tokens.ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (tokens.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) tok <= head.tok;
  end

  assign tokens.valid          = ov;
  assign tokens.token_kind     = tok.kind;
  assign tokens.start_position = tok.start;
  assign tokens.token_length   = tok.len;
  assign tokens.bad_char       = tok.bad;
  assign tokens.last_of_run    = tok.last;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> ov)
    else $error("loaded token not presented");

endmodule

>>> rtl/small_c_lexer_core.sv
// small_c_lexer_core: top level of the small C lexer; front mode machine,
// result queue and output register. Uses scl_pkg, scl_in_if, scl_out_if.
//
//   channel  dir  request             fields
//   chars    in   one byte or end     action, char_code
//   tokens   out  one token           token_kind, start_position, token_length,
//                                     bad_char, last_of_run
//
// One character request per cycle while chars.ready is high; 0-2 tokens each.
// 1 token per cycle out while tokens.ready is high, via queue and output register.
// chars.ready drops while the 4-entry result queue has fewer than 2 free slots.
// Reset (rst, synchronous) returns the lexer to idle with position zero.
module small_c_lexer_core #(
  parameter int KEYWORD_CHARS = scl_pkg::DEF_KEYWORD_CHARS,
  parameter int POSITION_BITS = scl_pkg::DEF_POSITION_BITS
) (
  input  logic      clk,
  input  logic      rst,
  scl_in_if.sink    chars,
  scl_out_if.source tokens
);
  import scl_pkg::*;

  push_t   push;
  logic    room;
  q_head_t head;
  logic    pop;

  scl_front #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .push  (push),
    .room  (room)
  );

  scl_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .head (head),
    .pop  (pop)
  );

  scl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule
